/* rtl/pcl_soft_font_stream_parser_defines.svh */
// assertion macros shared by the parser files
`ifndef PCL_SOFT_FONT_STREAM_PARSER_DEFINES_SVH
`define PCL_SOFT_FONT_STREAM_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
`define PCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PCL_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define PCL_ASSERT(lbl, prop, msg)
`define PCL_ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`endif

`endif

/* rtl/pcl_sf_pkg.sv */
package pcl_sf_pkg;

  localparam int unsigned MAX_HEADER = 4096;
  localparam logic [7:0]  ESC_BYTE   = 8'h1B;
  localparam logic [15:0] MIN_LAST   = 16'd127;
  localparam logic [30:0] NUM_MAX    = 31'h7FFF_FFFF;
  localparam logic [11:0] CNT_MAX    = 12'd4095;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_CHAR   = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_ESC    = 3'd1;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd2;
  localparam logic [2:0] ERR_HEAD_LONG = 3'd3;
  localparam logic [2:0] ERR_RANGE     = 3'd4;
  localparam logic [2:0] ERR_NO_ID     = 3'd5;
  localparam logic [2:0] ERR_TRUNC     = 3'd6;

  typedef enum logic [3:0] {
    CL_ESC, CL_STAR, CL_RPAR, CL_LPAR, CL_C, CL_S, CL_DIGIT,
    CL_MINUS, CL_POINT, CL_E, CL_W, CL_OTHER
  } byte_class_e;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  data_byte;
    byte_class_e cls;
    logic [3:0]  digit;
  } token_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] char_code;
    logic [31:0] byte_offset;
    logic [30:0] data_size;
    logic [15:0] max_code;
    logic [15:0] font_scale;
    logic [2:0]  error_code;
  } out_item_t;

endpackage

/* rtl/pcl_sf_if.sv */
interface pcl_sf_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;
  modport source (output valid, func, data_byte, input ready);
  modport sink   (input valid, func, data_byte, output ready);
endinterface

interface pcl_sf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] char_code;
  logic [31:0] byte_offset;
  logic [30:0] data_size;
  logic [15:0] max_code;
  logic [15:0] font_scale;
  logic [2:0]  error_code;
  modport source (output valid, kind, char_code, byte_offset, data_size, max_code,
                  font_scale, error_code, input ready);
  modport sink   (input valid, kind, char_code, byte_offset, data_size, max_code,
                  font_scale, error_code, output ready);
endinterface

/* rtl/pcl_soft_font_stream_parser.sv */
// channel  dir  handshake     payload
// in_i     in   valid/ready   func, data_byte
// out_o    out  valid/ready   kind, char_code, byte_offset, data_size,
//                             max_code, font_scale, error_code
// one item per cycle unless the output is held; an item is parsed when popped from the queue
// its result is registered into the output register at the edge that parses it
// while the output register is held the queue fills its two entries, then input stalls
// reset clears all parser state at once, no clearing pass
module pcl_soft_font_stream_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  pcl_sf_in_if.sink     in_i,
  pcl_sf_out_if.source  out_o
);
  import pcl_sf_pkg::*;

  in_item_t  item;
  token_t    tok_in, tok_q;
  logic      q_full, q_valid, q_pop;
  out_item_t res;

  assign item.func      = in_i.func;
  assign item.data_byte = in_i.data_byte;
  assign in_i.ready     = !q_full;

  pcl_sf_front u_front (
    .item_i (item),
    .tok_o  (tok_in)
  );

  pcl_sf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_i.valid),
    .push_tok_i (tok_in),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .pop_tok_o  (tok_q)
  );

  pcl_sf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (q_valid),
    .tok_i       (tok_q),
    .tok_pop_o   (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  assign out_o.kind        = res.kind;
  assign out_o.char_code   = res.char_code;
  assign out_o.byte_offset = res.byte_offset;
  assign out_o.data_size   = res.data_size;
  assign out_o.max_code    = res.max_code;
  assign out_o.font_scale  = res.font_scale;
  assign out_o.error_code  = res.error_code;

endmodule

/* rtl/pcl_sf_front.sv */
module pcl_sf_front (
  input  pcl_sf_pkg::in_item_t item_i,
  output pcl_sf_pkg::token_t   tok_o
);
  import pcl_sf_pkg::*;

  always_comb begin
    tok_o.func      = item_i.func;
    tok_o.data_byte = item_i.data_byte;
    tok_o.digit     = item_i.data_byte[3:0];
    if (item_i.data_byte >= "0" && item_i.data_byte <= "9") begin
      tok_o.cls = CL_DIGIT;
    end else begin
      unique case (item_i.data_byte)
        ESC_BYTE: tok_o.cls = CL_ESC;
        "*":      tok_o.cls = CL_STAR;
        ")":      tok_o.cls = CL_RPAR;
        "(":      tok_o.cls = CL_LPAR;
        "c":      tok_o.cls = CL_C;
        "s":      tok_o.cls = CL_S;
        "-":      tok_o.cls = CL_MINUS;
        ".":      tok_o.cls = CL_POINT;
        "E":      tok_o.cls = CL_E;
        "W":      tok_o.cls = CL_W;
        default:  tok_o.cls = CL_OTHER;
      endcase
    end
  end

endmodule

/* rtl/pcl_sf_queue.sv */
module pcl_sf_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pcl_sf_pkg::token_t push_tok_i,
  output logic               full_o,
  output logic               valid_o,
  input  logic               pop_i,
  output pcl_sf_pkg::token_t pop_tok_o
);
  import pcl_sf_pkg::*;

  token_t     mem_q [QDEPTH];
  logic [0:0] wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o    = (cnt_q == 2'(QDEPTH));
  assign valid_o   = (cnt_q != 2'd0);
  assign pop_tok_o = mem_q[rptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && valid_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + 2'd1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_tok_i;
  end

`include "pcl_soft_font_stream_parser_defines.svh"
  `PCL_ASSERT(a_q_cnt_ptr, (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wptr_q == rptr_q), "queue ptrs")
  `PCL_ASSERT(a_q_bound, cnt_q <= 2'(QDEPTH), "queue overflow")
  `PCL_ASSERT(a_q_track, (push_i && !full_o && !pop_i) |=> (cnt_q == $past(cnt_q) + 2'd1), "cnt")

endmodule

/* rtl/pcl_sf_back.sv */
module pcl_sf_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tok_valid_i,
  input  pcl_sf_pkg::token_t    tok_i,
  output logic                  tok_pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output pcl_sf_pkg::out_item_t out_o
);
  import pcl_sf_pkg::*;

  typedef enum logic [2:0] {PH_IDLE, PH_ESC, PH_FIRST, PH_NUMBER, PH_PAYLOAD} phase_e;
  typedef enum logic [1:0] {CMD_NONE, CMD_ID, CMD_HEAD, CMD_DATA} cmd_e;

  phase_e      phase_q, phase_d;
  cmd_e        cmd_q, cmd_d;
  logic [30:0] num_q, num_d;
  logic        point_q, point_d;
  logic [31:0] pos_q, pos_d;
  logic [30:0] left_q, left_d;
  logic        is_head_q, is_head_d;
  logic [11:0] hcnt_q, hcnt_d;
  logic [15:0] last_q, last_d;
  logic [15:0] scale_q, scale_d;
  logic [15:0] high_q, high_d;
  logic        hseen_q, hseen_d;
  logic [15:0] cur_q, cur_d;
  logic        idseen_q, idseen_d;
  logic        halted_q, halted_d;
  logic        out_valid_q;
  out_item_t   out_q, res;
  logic        res_valid;
  logic [34:0] prod;
  logic [30:0] left_dec;
  logic [15:0] li;

  assign tok_pop_o   = tok_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign prod = {1'b0, num_q, 3'b0} + {3'b0, num_q, 1'b0} + {31'b0, tok_i.digit};
  assign left_dec = (left_q != '0) ? left_q - 31'd1 : left_q;

  always_comb begin
    phase_d = phase_q; cmd_d = cmd_q; num_d = num_q; point_d = point_q;
    pos_d = pos_q; left_d = left_q; is_head_d = is_head_q; hcnt_d = hcnt_q;
    last_d = last_q; scale_d = scale_q; high_d = high_q; hseen_d = hseen_q;
    cur_d = cur_q; idseen_d = idseen_q; halted_d = halted_q;
    res_valid = 1'b0;
    res = '0;
    if (tok_pop_o) begin
      if (tok_i.func) begin
        if (!halted_q) begin
          res_valid = 1'b1;
          if (phase_q == PH_IDLE) begin
            res.kind = KIND_END;
          end else begin
            res.kind = KIND_ERROR;
            res.error_code = ERR_TRUNC;
          end
        end
        phase_d = PH_IDLE; cmd_d = CMD_NONE; num_d = '0; point_d = 1'b0;
        pos_d = '0; left_d = '0; is_head_d = 1'b0; hcnt_d = '0; last_d = '0;
        scale_d = '0; high_d = '0; hseen_d = 1'b0; cur_d = '0; idseen_d = 1'b0;
        halted_d = 1'b0;
      end else begin
        pos_d = pos_q + 32'd1;
        if (!halted_q) begin
          unique case (phase_q)
            PH_IDLE: begin
              if (tok_i.cls == CL_ESC) phase_d = PH_ESC;
              else begin
                res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_NO_ESC;
              end
            end
            PH_ESC: begin
              phase_d = PH_FIRST;
              case (tok_i.cls)
                CL_STAR: cmd_d = CMD_ID;
                CL_RPAR: cmd_d = CMD_HEAD;
                CL_LPAR: cmd_d = CMD_DATA;
                default: begin
                  res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_UNKNOWN;
                end
              endcase
            end
            PH_FIRST: begin
              if ((cmd_q == CMD_ID) ? (tok_i.cls == CL_C) : (tok_i.cls == CL_S)) begin
                num_d = '0; point_d = 1'b0; phase_d = PH_NUMBER;
              end else begin
                res_valid = 1'b1; res.kind = KIND_ERROR; res.error_code = ERR_UNKNOWN;
              end
            end
            PH_NUMBER: begin
              case (tok_i.cls)
                CL_DIGIT: begin
                  if (!point_q) num_d = (prod > {4'b0, NUM_MAX}) ? NUM_MAX : prod[30:0];
                end
                CL_MINUS: ;
                CL_POINT: point_d = 1'b1;
                default: begin
                  res_valid = 1'b1; res.kind = KIND_ERROR;
                  if (cmd_q == CMD_ID) begin
                    if (tok_i.cls != CL_E) res.error_code = ERR_UNKNOWN;
                    else if (num_q > 31'h0000_FFFF) res.error_code = ERR_RANGE;
                    else begin
                      res_valid = 1'b0; cur_d = num_q[15:0]; idseen_d = 1'b1;
                      phase_d = PH_IDLE;
                    end
                  end else if (tok_i.cls != CL_W) begin
                    res.error_code = ERR_UNKNOWN;
                  end else if (cmd_q == CMD_HEAD) begin
                    if (num_q >= 31'(MAX_HEADER)) res.error_code = ERR_HEAD_LONG;
                    else begin
                      is_head_d = 1'b1; hcnt_d = '0; last_d = '0; scale_d = '0;
                      left_d = num_q;
                      if (num_q == '0) begin
                        res.kind = KIND_HEADER;
                        high_d = MIN_LAST; hseen_d = 1'b1; is_head_d = 1'b0;
                        phase_d = PH_IDLE;
                      end else begin
                        res_valid = 1'b0; phase_d = PH_PAYLOAD;
                      end
                    end
                  end else if (!idseen_q) begin
                    res.error_code = ERR_NO_ID;
                  end else if (!hseen_q || cur_q > high_q) begin
                    res.error_code = ERR_RANGE;
                  end else begin
                    res.kind = KIND_CHAR; res.char_code = cur_q;
                    res.byte_offset = pos_q + 32'd1; res.data_size = num_q;
                    is_head_d = 1'b0; left_d = num_q;
                    phase_d = (num_q == '0) ? PH_IDLE : PH_PAYLOAD;
                  end
                  if (res_valid && res.kind == KIND_ERROR) halted_d = 1'b1;
                  if (res_valid && res.kind == KIND_ERROR) phase_d = PH_IDLE;
                end
              endcase
            end
            PH_PAYLOAD: begin
              if (is_head_q) begin
                case (hcnt_q)
                  12'd38:  last_d[15:8] = tok_i.data_byte;
                  12'd39:  last_d[7:0] = tok_i.data_byte;
                  12'd64:  scale_d[15:8] = tok_i.data_byte;
                  12'd65:  scale_d[7:0] = tok_i.data_byte;
                  default: ;
                endcase
                if (hcnt_q < CNT_MAX) hcnt_d = hcnt_q + 12'd1;
              end
              left_d = left_dec;
              if (left_dec == '0) begin
                phase_d = PH_IDLE;
                if (is_head_q) begin
                  res_valid = 1'b1; res.kind = KIND_HEADER;
                  high_d = (last_d > MIN_LAST) ? last_d : MIN_LAST;
                  hseen_d = 1'b1; is_head_d = 1'b0;
                end
              end
            end
            default: phase_d = PH_IDLE;
          endcase
          // every error on a data byte halts the parser
          if (res_valid && res.kind == KIND_ERROR) begin
            halted_d = 1'b1; phase_d = PH_IDLE;
          end
        end
      end
    end
    li = tok_i.func ? high_q : high_d;
    res.max_code = (li > MIN_LAST) ? li : MIN_LAST;
    res.font_scale = tok_i.func ? scale_q : scale_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; cmd_q <= CMD_NONE; num_q <= '0; point_q <= 1'b0;
      pos_q <= '0; left_q <= '0; is_head_q <= 1'b0; hcnt_q <= '0; last_q <= '0;
      scale_q <= '0; high_q <= '0; hseen_q <= 1'b0; cur_q <= '0; idseen_q <= 1'b0;
      halted_q <= 1'b0; out_valid_q <= 1'b0; out_q <= '0;
    end else begin
      phase_q <= phase_d; cmd_q <= cmd_d; num_q <= num_d; point_q <= point_d;
      pos_q <= pos_d; left_q <= left_d; is_head_q <= is_head_d; hcnt_q <= hcnt_d;
      last_q <= last_d; scale_q <= scale_d; high_q <= high_d; hseen_q <= hseen_d;
      cur_q <= cur_d; idseen_q <= idseen_d; halted_q <= halted_d;
      if (res_valid) begin
        out_valid_q <= 1'b1;
        out_q <= res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

`include "pcl_soft_font_stream_parser_defines.svh"
  `PCL_ASSERT(a_pop_room, tok_pop_o |-> (!out_valid_q || out_ready_i), "pop without room")
  `PCL_ASSERT(a_halt_quiet, (tok_pop_o && halted_q && !tok_i.func) |-> !res_valid, "halted")
  `PCL_ASSERT(a_eos_rearm, (tok_pop_o && tok_i.func) |=> (phase_q == PH_IDLE && !halted_q), "eos")
  `PCL_ASSERT(a_payload_left, (phase_q == PH_PAYLOAD) |-> (left_q != '0), "payload count")

endmodule
